// ===== hdl/isc_pkg.sv =====
`default_nettype none

package isc_pkg;

  // Number of register stages from the input register to the result register.
  localparam int NUM_STAGES = 5;

  // Configuration register indexes.
  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t REG_ACCEL_OFFSET_X = 3'd0;
  localparam cfg_index_t REG_ACCEL_OFFSET_Y = 3'd1;
  localparam cfg_index_t REG_ACCEL_OFFSET_Z = 3'd2;
  localparam cfg_index_t REG_GYRO_OFFSET_X  = 3'd3;
  localparam cfg_index_t REG_GYRO_OFFSET_Y  = 3'd4;
  localparam cfg_index_t REG_GYRO_OFFSET_Z  = 3'd5;

  // Temperature conversion: (TEMP_BASE + raw*10/34) / 10.
  // raw*10/34 equals floor(|raw| * 5/17), taken as |raw| * TEMP_RECIP >> TEMP_SHIFT.
  localparam int TEMP_SHIFT = 24;
  localparam logic [22:0] TEMP_RECIP = 23'd4934476;
  localparam int TEMP_Q_W = 14;
  localparam logic [13:0] TEMP_BASE = 14'd3653;
  // Division by ten of a value below 2^14: value * TENTHS_RECIP >> TENTHS_SHIFT.
  localparam int TENTHS_SHIFT = 18;
  localparam logic [14:0] TENTHS_RECIP = 15'd26215;
  localparam int TENTHS_Q_W = 11;

  // One raw inertial sample.
  typedef struct packed {
    logic [15:0] accel_x_raw;
    logic [15:0] accel_y_raw;
    logic [15:0] accel_z_raw;
    logic [15:0] temp_raw;
    logic [15:0] gyro_x_raw;
    logic [15:0] gyro_y_raw;
    logic [15:0] gyro_z_raw;
  } sample_t;

  // One conditioned result.
  typedef struct packed {
    logic signed [15:0] accel_x_avg;
    logic signed [15:0] accel_y_avg;
    logic signed [15:0] accel_z_avg;
    logic signed [11:0] temp_tenths;
    logic signed [15:0] gyro_x_out;
    logic signed [15:0] gyro_y_out;
    logic signed [15:0] gyro_z_out;
  } result_t;

  // Offsets held by the configuration registers.
  typedef struct packed {
    logic [2:0][15:0] accel;
    logic [2:0][15:0] gyro;
  } offsets_t;

  // Load enables of the pipeline stages, stage 0 being the input register.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/isc_sample_if.sv =====
`default_nettype none

interface isc_sample_if;
  logic valid;
  logic ready;
  isc_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/isc_result_if.sv =====
`default_nettype none

interface isc_result_if;
  logic valid;
  logic ready;
  isc_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/isc_cfg_if.sv =====
`default_nettype none

interface isc_cfg_if;
  logic valid;
  logic ready;
  isc_pkg::cfg_index_t index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/isc_cfg_regs.sv =====
`default_nettype none

module isc_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  isc_cfg_if.sink             cfg,
  output isc_pkg::offsets_t   offsets
);

  // Register writes are always taken at once.
  assign cfg.ready = 1'b1;

  // Offset registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        isc_pkg::REG_ACCEL_OFFSET_X: offsets.accel[0] <= cfg.data;
        isc_pkg::REG_ACCEL_OFFSET_Y: offsets.accel[1] <= cfg.data;
        isc_pkg::REG_ACCEL_OFFSET_Z: offsets.accel[2] <= cfg.data;
        isc_pkg::REG_GYRO_OFFSET_X:  offsets.gyro[0]  <= cfg.data;
        isc_pkg::REG_GYRO_OFFSET_Y:  offsets.gyro[1]  <= cfg.data;
        isc_pkg::REG_GYRO_OFFSET_Z:  offsets.gyro[2]  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/isc_accel_path.sv =====
`default_nettype none

module isc_accel_path #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire isc_pkg::pipe_ctl_t  ctl,
  input  wire logic [2:0][15:0]    raw,
  input  wire logic [2:0][15:0]    offset,
  output logic [2:0][15:0]         avg
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
  localparam int SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int RECIP_W = SUM_W + 1;
  localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

  // Ring of corrected samples, one row holds all three axes.
  logic [2:0][15:0] ring [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] row_valid;
  logic [SLOT_W-1:0] write_slot;

  logic [2:0][15:0] corr1;
  logic [2:0][15:0] old1;
  logic old_valid1;
  logic [SLOT_W-1:0] slot1;

  logic signed [SUM_W-1:0] sums [3];
  logic [SUM_W-1:0] mag3 [3];
  logic [2:0] neg3;
  logic [PROD_W-1:0] prod4 [3];
  logic [2:0] neg4;

  // Stage 1: offset correction, ring read at the current slot.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      for (int a = 0; a < 3; a++) begin
        corr1[a] <= raw[a] - offset[a];
      end
      old1 <= ring[write_slot];
      old_valid1 <= row_valid[write_slot];
      slot1 <= write_slot;
    end
  end

  // Ring write as the sample moves on to the sum stage.
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      ring[slot1] <= corr1;
    end
  end

  // Slot pointer and row valid bits; a row never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      row_valid <= '0;
    end else begin
      if (ctl.load[0]) begin
        write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      end
      if (ctl.load[1]) begin
        row_valid[slot1] <= 1'b1;
      end
    end
  end

  // Stage 2: running window sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        sums[a] <= '0;
      end
    end else if (ctl.load[1]) begin
      for (int a = 0; a < 3; a++) begin
        sums[a] <= sums[a] + SUM_W'(signed'(corr1[a]))
                   - (old_valid1 ? SUM_W'(signed'(old1[a])) : '0);
      end
    end
  end

  // Stage 3: magnitude and sign of each sum.
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      for (int a = 0; a < 3; a++) begin
        neg3[a] <= sums[a][SUM_W-1];
        mag3[a] <= sums[a][SUM_W-1] ? SUM_W'(-sums[a]) : SUM_W'(sums[a]);
      end
    end
  end

  // Stage 4: multiply by the reciprocal of the window length.
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      for (int a = 0; a < 3; a++) begin
        prod4[a] <= PROD_W'(mag3[a]) * PROD_W'(RECIP_V);
      end
      neg4 <= neg3;
    end
  end

  // Stage 5: quotient with the sign restored, truncated toward zero.
  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      for (int a = 0; a < 3; a++) begin
        avg[a] <= neg4[a] ? 16'(-prod4[a][SHIFT +: 16]) : prod4[a][SHIFT +: 16];
      end
    end
  end

`ifndef SYNTHESIS
  localparam int SUM_MAX = WINDOW_LEN * 32767;
  localparam int SUM_MIN = -(WINDOW_LEN * 32768);

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LAST_SLOT)
    else $error("write slot beyond the window");

  a_sum_bounds: assert property (@(posedge clk) disable iff (rst)
    sums[0] <= SUM_MAX && sums[0] >= SUM_MIN &&
    sums[1] <= SUM_MAX && sums[1] >= SUM_MIN &&
    sums[2] <= SUM_MAX && sums[2] >= SUM_MIN)
    else $error("window sum outside what the ring can hold");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    ctl.load[1] |=> row_valid[$past(slot1)])
    else $error("written ring row not marked valid");
`endif

endmodule

`default_nettype wire

// ===== hdl/isc_aux_path.sv =====
`default_nettype none

module isc_aux_path (
  input  wire logic                clk,
  input  wire isc_pkg::pipe_ctl_t  ctl,
  input  wire logic [15:0]         temp_raw,
  input  wire logic [2:0][15:0]    gyro_raw,
  input  wire logic [2:0][15:0]    gyro_offset,
  output logic signed [11:0]       temp_tenths,
  output logic [2:0][15:0]         gyro_out
);

  localparam int TPROD1_W = 39;
  localparam int TPROD2_W = 29;

  logic [15:0] tmag1;
  logic tneg1;
  logic [TPROD1_W-1:0] tprod2;
  logic tneg2;
  logic [isc_pkg::TEMP_Q_W-1:0] tq;
  logic [13:0] tmag3;
  logic tneg3;
  logic [TPROD2_W-1:0] tprod4;
  logic tneg4;
  logic [isc_pkg::TENTHS_Q_W-1:0] tenths_q;
  logic [2:0][15:0] gyro_s [4];

  // Stage 1: temperature magnitude and sign, gyro offset correction.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      tneg1 <= temp_raw[15];
      tmag1 <= temp_raw[15] ? 16'(-temp_raw) : temp_raw;
      for (int a = 0; a < 3; a++) begin
        gyro_s[0][a] <= gyro_raw[a] - gyro_offset[a];
      end
    end
  end

  // Stage 2: scale by 10/34 through a reciprocal product.
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      tprod2 <= TPROD1_W'(tmag1) * TPROD1_W'(isc_pkg::TEMP_RECIP);
      tneg2 <= tneg1;
      gyro_s[1] <= gyro_s[0];
    end
  end

  // Stage 3: add the base, keeping magnitude and sign apart.
  assign tq = tprod2[isc_pkg::TEMP_SHIFT +: isc_pkg::TEMP_Q_W];

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      if (!tneg2) begin
        tmag3 <= isc_pkg::TEMP_BASE + tq;
        tneg3 <= 1'b0;
      end else if (tq > isc_pkg::TEMP_BASE) begin
        tmag3 <= tq - isc_pkg::TEMP_BASE;
        tneg3 <= 1'b1;
      end else begin
        tmag3 <= isc_pkg::TEMP_BASE - tq;
        tneg3 <= 1'b0;
      end
      gyro_s[2] <= gyro_s[1];
    end
  end

  // Stage 4: divide by ten through a reciprocal product.
  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      tprod4 <= TPROD2_W'(tmag3) * TPROD2_W'(isc_pkg::TENTHS_RECIP);
      tneg4 <= tneg3;
      gyro_s[3] <= gyro_s[2];
    end
  end

  // Stage 5: signed tenths of a degree and the corrected gyro words.
  assign tenths_q = tprod4[isc_pkg::TENTHS_SHIFT +: isc_pkg::TENTHS_Q_W];

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      temp_tenths <= tneg4 ? -signed'({1'b0, tenths_q}) : signed'({1'b0, tenths_q});
      gyro_out <= gyro_s[3];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_sample_conditioner_top.sv =====
// Throughput: one sample per cycle while no result waits for results.ready;
// each stage holds one sample and moves on whenever the stage after it is
// empty or moving, so a waiting result stalls only the stages behind it.
// Reset (synchronous) clears the offsets, the ring row valid bits, the slot
// pointer, the window sums and the stage valid bits.
`default_nettype none

module imu_sample_conditioner_top #(
  parameter int WINDOW_LEN = 10
) (
  input  wire logic     clk,
  input  wire logic     rst,
  isc_sample_if.sink    samples,
  isc_result_if.source  results,
  isc_cfg_if.sink       cfg
);

  localparam int NS = isc_pkg::NUM_STAGES;

  logic [NS-1:0] stage_valid;
  logic [NS-1:0] can_load;
  isc_pkg::pipe_ctl_t ctl;
  isc_pkg::offsets_t offsets;
  logic [2:0][15:0] accel_raw;
  logic [2:0][15:0] gyro_raw;
  logic [2:0][15:0] accel_avg;
  logic [2:0][15:0] gyro_out;
  logic signed [11:0] temp_tenths;
  isc_pkg::result_t res;

  // A stage can load when it is empty or its content moves on.
  always_comb begin
    can_load[NS-1] = !stage_valid[NS-1] || results.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      can_load[k] = !stage_valid[k] || can_load[k+1];
    end
    ctl.load[0] = samples.valid && can_load[0];
    for (int k = 1; k < NS; k++) begin
      ctl.load[k] = stage_valid[k-1] && can_load[k];
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (can_load[0]) begin
        stage_valid[0] <= samples.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (can_load[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign samples.ready = can_load[0];
  assign results.valid = stage_valid[NS-1];

  assign accel_raw[0] = samples.data.accel_x_raw;
  assign accel_raw[1] = samples.data.accel_y_raw;
  assign accel_raw[2] = samples.data.accel_z_raw;
  assign gyro_raw[0] = samples.data.gyro_x_raw;
  assign gyro_raw[1] = samples.data.gyro_y_raw;
  assign gyro_raw[2] = samples.data.gyro_z_raw;

  isc_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .offsets (offsets)
  );

  isc_accel_path #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_accel_path (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .raw    (accel_raw),
    .offset (offsets.accel),
    .avg    (accel_avg)
  );

  isc_aux_path u_aux_path (
    .clk         (clk),
    .ctl         (ctl),
    .temp_raw    (samples.data.temp_raw),
    .gyro_raw    (gyro_raw),
    .gyro_offset (offsets.gyro),
    .temp_tenths (temp_tenths),
    .gyro_out    (gyro_out)
  );

  // Result payload.
  always_comb begin
    res.accel_x_avg = accel_avg[0];
    res.accel_y_avg = accel_avg[1];
    res.accel_z_avg = accel_avg[2];
    res.temp_tenths = temp_tenths;
    res.gyro_x_out = gyro_out[0];
    res.gyro_y_out = gyro_out[1];
    res.gyro_z_out = gyro_out[2];
  end

  assign results.data = res;

`ifndef SYNTHESIS
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (results.valid && !results.ready))
    else $error("sample request refused while the pipeline can move");
`endif

endmodule

`default_nettype wire
